// ===== hw/rtl/hbfc_pkg.sv =====
`timescale 1ns / 1ps

package hbfc_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int POS_W      = 8;
    localparam int ATLAS_W    = 3;
    localparam int LEVEL_W    = 8;
    localparam int NUM_LEVELS = 7;
    localparam int CLS_W      = 3;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [ATLAS_W-1:0]    atlas_idx_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef level_t [NUM_LEVELS-1:0] levels_t;
    typedef logic [CLS_W-1:0]      cls_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;

    // register indexes
    localparam reg_idx_t REG_MOUNTAIN_TOP = 3'd0;
    localparam reg_idx_t REG_MOUNTAIN_MID = 3'd1;
    localparam reg_idx_t REG_MOUNTAIN_LOW = 3'd2;
    localparam reg_idx_t REG_PLAINS_TOP   = 3'd3;
    localparam reg_idx_t REG_PLAINS_MID   = 3'd4;
    localparam reg_idx_t REG_PLAINS_LOW   = 3'd5;
    localparam reg_idx_t REG_PLAINS_SUB   = 3'd6;

    // terrain classes, in threshold order
    localparam cls_t CLS_MOUNTAIN_TOP = 3'd0;
    localparam cls_t CLS_MOUNTAIN_MID = 3'd1;
    localparam cls_t CLS_MOUNTAIN_LOW = 3'd2;
    localparam cls_t CLS_PLAINS_TOP   = 3'd3;
    localparam cls_t CLS_PLAINS_MID   = 3'd4;
    localparam cls_t CLS_PLAINS_LOW   = 3'd5;
    localparam cls_t CLS_PLAINS_SUB   = 3'd6;
    localparam cls_t CLS_SEA_GROUND   = 3'd7;

    // entry 0 is the rightmost element
    localparam levels_t LEVEL_RESET = {8'd20, 8'd50, 8'd80, 8'd110, 8'd140, 8'd170, 8'd200};

    typedef struct packed {
        atlas_idx_t col;
        atlas_idx_t row;
    } atlas_t;

    // One window, as handed from the line store stage to the classifier.
    typedef struct packed {
        sample_t store_up;    // previous column, row above
        sample_t store_lo;    // previous column, this row
        sample_t left_up;     // this column, row above
        sample_t cur;         // this column, this row (after border forcing)
        pos_t    tile_col;
        pos_t    tile_row;
        logic    emit;
        logic    done;
    } window_t;

    // First threshold exceeded wins; none exceeded is sea ground.
    function automatic cls_t classify(input sample_t h, input levels_t lv);
        cls_t c;
        c = CLS_SEA_GROUND;
        for (int k = NUM_LEVELS - 1; k >= 0; k--)
        begin
            if (h > lv[k])
            begin
                c = cls_t'(k);
            end
        end
        return c;
    endfunction

    function automatic atlas_t atlas_lookup(input cls_t c);
        atlas_t a;
        case (c) inside
            CLS_MOUNTAIN_TOP:               a = '{col: 3'd0, row: 3'd1};
            CLS_MOUNTAIN_MID:               a = '{col: 3'd0, row: 3'd0};
            CLS_MOUNTAIN_LOW:               a = '{col: 3'd3, row: 3'd2};
            CLS_PLAINS_TOP:                 a = '{col: 3'd2, row: 3'd2};
            CLS_PLAINS_MID:                 a = '{col: 3'd6, row: 3'd3};
            CLS_PLAINS_LOW:                 a = '{col: 3'd0, row: 3'd4};
            CLS_PLAINS_SUB, CLS_SEA_GROUND: a = '{col: 3'd3, row: 3'd3};
            default:                        a = '{col: 3'd3, row: 3'd3};
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/hbfc_if.sv =====
`timescale 1ns / 1ps

interface hbfc_in_if
    import hbfc_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    map_start;

    modport source (output valid, output sample, output map_start, input ready);
    modport sink   (input valid, input sample, input map_start, output ready);
endinterface

interface hbfc_out_if
    import hbfc_pkg::*;
;
    logic       valid;
    logic       ready;
    pos_t       tile_col;
    pos_t       tile_row;
    sample_t    mean_height;
    atlas_idx_t atlas_col;
    atlas_idx_t atlas_row;
    logic       map_done;

    modport source (output valid, output tile_col, output tile_row, output mean_height,
                    output atlas_col, output atlas_row, output map_done, input ready);
    modport sink   (input valid, input tile_col, input tile_row, input mean_height,
                    input atlas_col, input atlas_row, input map_done, output ready);
endinterface

// ===== hw/rtl/hbfc_cfg.sv =====
`timescale 1ns / 1ps

module hbfc_cfg
    import hbfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output levels_t               levels
);

    levels_t  levels_reg;
    reg_idx_t idx;
    logic     idx_ok;

    assign idx    = paddr[4:2];
    assign idx_ok = (idx <= REG_PLAINS_SUB);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVEL_RESET;
        end
        else if (psel && penable && pwrite && idx_ok)
        begin
            levels_reg[idx] <= pwdata[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx_ok)
        begin
            prdata = APB_DATA_W'(levels_reg[idx]);
        end
    end

    assign levels = levels_reg;

endmodule

// ===== hw/rtl/hbfc_linebuf.sv =====
`timescale 1ns / 1ps

module hbfc_linebuf
    import hbfc_pkg::*;
#(
    parameter int GRID_X = 128,
    parameter int GRID_Z = 128
)
(
    input  logic      clk,
    input  logic      rst_n,
    hbfc_in_if.sink   sample_ch,
    input  logic      advance,
    output logic      win_valid,
    output window_t   win
);

    localparam int DEPTH = GRID_Z + 2;
    localparam int COL_W = $clog2(GRID_X + 2);
    localparam int ROW_W = $clog2(DEPTH);
    localparam logic [COL_W-1:0] COL_EDGE = COL_W'(GRID_X);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_X + 1);
    localparam logic [ROW_W-1:0] ROW_EDGE = ROW_W'(GRID_Z);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_Z + 1);

    logic [COL_W-1:0] col_reg, col_now, col_next, col_m1;
    logic [ROW_W-1:0] row_reg, row_now, row_next, row_m1, wr_addr;
    sample_t          prev_reg;
    sample_t          rd_reg;
    sample_t          cur;
    logic             border;
    logic             fire;
    logic             s1_valid_reg;
    window_t          s1_reg;

    sample_t store_mem [DEPTH];

    assign sample_ch.ready = !s1_valid_reg || advance;
    assign fire            = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        col_now = sample_ch.map_start ? '0 : col_reg;
        row_now = sample_ch.map_start ? '0 : row_reg;
        col_m1  = col_now - 1'b1;
        row_m1  = row_now - 1'b1;
        border  = (col_now == '0) || (col_now == COL_EDGE)
               || (row_now == '0) || (row_now == ROW_EDGE);
        cur     = border ? '0 : sample_ch.sample;
        // row 0 finishes the deferred write of the previous column's last row
        wr_addr = (row_now == '0) ? ROW_LAST : row_m1;
        if (row_now == ROW_LAST)
        begin
            row_next = '0;
            col_next = (col_now == COL_LAST) ? '0 : col_now + 1'b1;
        end
        else
        begin
            row_next = row_now + 1'b1;
            col_next = col_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                prev_reg <= cur;
            end
            if (fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Line store: read this row of the previous column, write the row above.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            store_mem[wr_addr] <= prev_reg;
            rd_reg             <= store_mem[row_now];
        end
    end

    // rd_reg still holds the row above (read one item earlier) at this edge.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_reg.store_up <= rd_reg;
            s1_reg.store_lo <= '0;
            s1_reg.left_up  <= prev_reg;
            s1_reg.cur      <= cur;
            s1_reg.tile_col <= POS_W'(col_m1);
            s1_reg.tile_row <= POS_W'(row_m1);
            s1_reg.emit     <= (row_now != '0) && (col_now != '0);
            s1_reg.done     <= (col_now == COL_LAST) && (row_now == ROW_LAST);
        end
    end

    always_comb
    begin
        win          = s1_reg;
        win.store_lo = rd_reg;
    end

    assign win_valid = s1_valid_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
        else $error("grid position out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && sample_ch.map_start |=> (col_reg == '0) && (row_reg == ROW_W'(1)))
        else $error("map_start did not restart the position");

endmodule

// ===== hw/rtl/hbfc_classify.sv =====
`timescale 1ns / 1ps

module hbfc_classify
    import hbfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  levels_t    levels,
    input  logic       win_valid,
    input  window_t    win,
    output logic       advance,
    hbfc_out_if.source tile_ch
);

    logic [SUM_W-1:0] sum;
    sample_t          mean;
    atlas_t           atlas;
    logic             load;
    logic             out_valid_reg;
    pos_t             tile_col_reg;
    pos_t             tile_row_reg;
    sample_t          mean_reg;
    atlas_t           atlas_reg;
    logic             done_reg;

    always_comb
    begin
        sum   = SUM_W'(win.store_up) + SUM_W'(win.store_lo)
              + SUM_W'(win.left_up) + SUM_W'(win.cur);
        mean  = sum[SUM_W-1:2];
        atlas = atlas_lookup(classify(mean, levels));
    end

    assign advance = !out_valid_reg || tile_ch.ready;
    assign load    = advance && win_valid && win.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= win_valid && win.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tile_col_reg <= win.tile_col;
            tile_row_reg <= win.tile_row;
            mean_reg     <= mean;
            atlas_reg    <= atlas;
            done_reg     <= win.done;
        end
    end

    assign tile_ch.valid       = out_valid_reg;
    assign tile_ch.tile_col    = tile_col_reg;
    assign tile_ch.tile_row    = tile_row_reg;
    assign tile_ch.mean_height = mean_reg;
    assign tile_ch.atlas_col   = atlas_reg.col;
    assign tile_ch.atlas_row   = atlas_reg.row;
    assign tile_ch.map_done    = done_reg;

    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid && !advance |=> win_valid && $stable(win))
        else $error("window changed while the result register was full");

endmodule

// ===== hw/rtl/heightmap_box_filter_classifier.sv =====
`timescale 1ns / 1ps

// Heightmap 2x2 box filter and terrain classifier. Height samples of a padded
// (GRID_X+2) x (GRID_Z+2) grid arrive one item per cycle while sample_ch.ready
// is high, row index fastest; map_start on an item restarts the position at
// column 0, row 0, and after the last sample of a grid the position wraps on
// its own. Samples on column 0, column GRID_X, row 0 and row GRID_Z are forced
// to zero. Each item from row 1 and column 1 on closes a 2x2 window and produces
// one result item: window top-left position, truncated mean height, and the
// terrain atlas cell chosen by seven thresholds tested top down (first exceeded
// wins, else sea ground). Rate is one item per cycle with no bubbles while
// tile_ch.ready is high; an output stall holds back sample_ch.ready. The
// accepting edge loads the line store stage (one read and one write of the
// GRID_Z+2 entry column store per item), and from that stage the adder and
// threshold compare feed the result register once it has room. The column
// store needs no clearing pass after reset: column 0 rewrites every entry
// before any window reads it. Thresholds sit at APB byte addresses 0x00..0x18,
// one per word, and should be changed only while no items are in flight.
module heightmap_box_filter_classifier
    import hbfc_pkg::*;
#(
    parameter int GRID_X = 128,
    parameter int GRID_Z = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hbfc_in_if.sink               sample_ch,
    hbfc_out_if.source            tile_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    levels_t levels;
    logic    advance;
    logic    win_valid;
    window_t win;

    // threshold registers
    hbfc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .levels  (levels)
    );

    // position tracking, border forcing, column store
    hbfc_linebuf #(
        .GRID_X (GRID_X),
        .GRID_Z (GRID_Z)
    ) u_linebuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .advance   (advance),
        .win_valid (win_valid),
        .win       (win)
    );

    // mean, threshold classification, result register
    hbfc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .levels    (levels),
        .win_valid (win_valid),
        .win       (win),
        .advance   (advance),
        .tile_ch   (tile_ch)
    );

    // The last window of a grid sits at column GRID_X, row GRID_Z.
    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        tile_ch.valid && tile_ch.map_done |->
            (tile_ch.tile_col == POS_W'(GRID_X)) && (tile_ch.tile_row == POS_W'(GRID_Z)))
        else $error("map_done on a window other than the last");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Checks the heightmap box filter against a predictor that follows every sample.
// The predictor keeps its own grid position, previous column and threshold copy.
// Samples go out on the input channel with random idle bursts. Tiles are taken
// on the output channel with random stalls, plus one long hold that fills the
// pipe. Thresholds change over APB only when no item is in flight. Each change
// is read back before the next stretch of samples.
module testbench;
    import hbfc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int GRID_X      = 128;
    localparam int GRID_Z      = 128;
    localparam int COL_DEPTH   = GRID_Z + 2;
    localparam int LONG_RUN    = 2 * COL_DEPTH + 20;   // items sent under the long hold
    localparam int NUM_PHASES  = 6;
    localparam int RUN_BUDGET  = 100;     // random items per threshold setting
    localparam int LONG_HOLD   = 400;     // cycles the tile side holds off once
    localparam int SETTLE      = 8;       // covers the two-stage pipe with margin
    localparam int CYCLE_LIMIT = 2_000_000;

    // Index past the last threshold; writes there must be dropped.
    localparam reg_idx_t REG_UNMAPPED = 3'd7;

    localparam level_t LEVELS_AT_RESET [NUM_LEVELS] = '{8'd200, 8'd170, 8'd140, 8'd110,
                                                        8'd80, 8'd50, 8'd20};

    // Atlas cell per terrain class, sea ground last.
    localparam atlas_idx_t CLASS_ATLAS_COL [NUM_LEVELS+1] = '{3'd0, 3'd0, 3'd3, 3'd2,
                                                              3'd6, 3'd0, 3'd3, 3'd3};
    localparam atlas_idx_t CLASS_ATLAS_ROW [NUM_LEVELS+1] = '{3'd1, 3'd0, 3'd2, 3'd2,
                                                              3'd3, 3'd4, 3'd3, 3'd3};

    // How the samples of one run are made up.
    typedef enum int {FILL_RANDOM, FILL_FLAT, FILL_EXTREME, FILL_RAMP} fill_t;

    typedef struct packed {
        pos_t       col;
        pos_t       row;
        sample_t    mean;
        atlas_idx_t acol;
        atlas_idx_t arow;
        logic       done;
    } tile_t;

    // Follows the sample stream, queues the tile each sample produces and
    // compares the tiles coming out of the block in order.
    class tile_scoreboard_t;
        level_t  levels [NUM_LEVELS];
        sample_t col_store [COL_DEPTH];
        sample_t above;
        int      col_pos;
        int      row_pos;
        tile_t   tiles_due [$];
        int      mismatches;

        function new();
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                levels[k] = LEVELS_AT_RESET[k];
            end
            foreach (col_store[i])
            begin
                col_store[i] = '0;
            end
            above      = '0;
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
        endfunction

        function void set_level(input reg_idx_t idx, input level_t v);
            if (idx < NUM_LEVELS)
            begin
                levels[idx] = v;
            end
        endfunction

        // Thresholds are tried top down; the first one exceeded decides.
        function cls_t terrain(input sample_t h);
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                if (h > levels[k])
                begin
                    return cls_t'(k);
                end
            end
            return CLS_SEA_GROUND;
        endfunction

        function void take_sample(input sample_t s, input logic start);
            sample_t          v;
            logic [SUM_W-1:0] sum;
            tile_t            t;
            cls_t             c;
            if (start)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            v = s;
            if (col_pos == 0 || col_pos == GRID_X || row_pos == 0 || row_pos == GRID_Z)
            begin
                v = '0;
            end
            if (row_pos == 0)
            begin
                // bottom entry of the column just finished lands late
                col_store[COL_DEPTH-1] = above;
            end
            else
            begin
                if (col_pos >= 1)
                begin
                    sum = SUM_W'(col_store[row_pos-1]) + SUM_W'(col_store[row_pos])
                        + SUM_W'(above) + SUM_W'(v);
                    c      = terrain(sum[SUM_W-1:2]);
                    t.col  = pos_t'(col_pos - 1);
                    t.row  = pos_t'(row_pos - 1);
                    t.mean = sum[SUM_W-1:2];
                    t.acol = CLASS_ATLAS_COL[c];
                    t.arow = CLASS_ATLAS_ROW[c];
                    t.done = (col_pos == GRID_X + 1 && row_pos == GRID_Z + 1);
                    tiles_due.push_back(t);
                end
                col_store[row_pos-1] = above;
            end
            above = v;
            row_pos++;
            if (row_pos >= COL_DEPTH)
            begin
                row_pos = 0;
                col_pos++;
                if (col_pos >= GRID_X + 2)
                begin
                    col_pos = 0;
                end
            end
        endfunction

        function void flag(input string field, input tile_t want,
                           input logic [7:0] want_v, input logic [7:0] got_v);
            $display("%0t: tile (%0d,%0d) %s expected %0d, got %0d",
                     $time, want.col, want.row, field, want_v, got_v);
            mismatches++;
        endfunction

        function void check_tile(input tile_t got);
            tile_t want;
            if (tiles_due.size() == 0)
            begin
                $display("%0t: tile (%0d,%0d) expected none, got mean %0d",
                         $time, got.col, got.row, got.mean);
                mismatches++;
            end
            else
            begin
                want = tiles_due.pop_front();
                if (got.col !== want.col)   flag("tile_col", want, want.col, got.col);
                if (got.row !== want.row)   flag("tile_row", want, want.row, got.row);
                if (got.mean !== want.mean) flag("mean_height", want, want.mean, got.mean);
                if (got.acol !== want.acol) flag("atlas_col", want, 8'(want.acol), 8'(got.acol));
                if (got.arow !== want.arow) flag("atlas_row", want, 8'(want.arow), 8'(got.arow));
                if (got.done !== want.done) flag("map_done", want, 8'(want.done), 8'(got.done));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hbfc_in_if  sample_ch ();
    hbfc_out_if tile_ch ();

    tile_scoreboard_t tiles;

    bit          idle_on;          // random idle bursts on both channels
    bit          stalls_allowed;   // cleared for the last stretch of the run
    int unsigned hold_requests;    // bumped by the sample side to ask for a long hold
    int unsigned cycles;

    heightmap_box_filter_classifier #(
        .GRID_X (GRID_X),
        .GRID_Z (GRID_Z)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .tile_ch   (tile_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- APB side
    // One transfer: setup, access until pready, then psel low before returning, so
    // back-to-back calls never touch psel twice in one step.
    task automatic apb_transfer(input logic wr, input reg_idx_t idx, input level_t v,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), v};   // upper bits are noise, only 8 are kept
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_level(input reg_idx_t idx, input level_t v);
        logic [APB_DATA_W-1:0] unused;
        apb_transfer(1'b1, idx, v, unused);
        tiles.set_level(idx, v);
    endtask

    task automatic check_levels();
        logic [APB_DATA_W-1:0] got;
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            apb_transfer(1'b0, reg_idx_t'(k), '0, got);
            if (got !== APB_DATA_W'(tiles.levels[k]))
            begin
                $display("%0t: threshold %0d expected %0d, got %0d",
                         $time, k, tiles.levels[k], got);
                tiles.mismatches++;
            end
        end
    endtask

    // Threshold sets: all zero, all 255, ascending (the opposite of the
    // order they are tested in), and random.
    task automatic set_levels(input int phase);
        level_t v;
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            case (phase)
                1:       v = '0;
                2:       v = '1;
                4:       v = level_t'(20 + 30 * k);
                default: v = level_t'($urandom);
            endcase
            write_level(reg_idx_t'(k), v);
        end
        // a write past the last threshold must leave all of them alone
        if (phase == 3)
        begin
            write_level(REG_UNMAPPED, level_t'($urandom));
        end
    endtask

    // ------------------------------------------------------------- sample side
    // Offer one item and hold it until the block takes it. An idle burst, if
    // any, drops valid first; valid is never lowered and raised in one step.
    task automatic offer_sample(input sample_t s, input logic start);
        if (idle_on && $urandom_range(0, 15) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample    <= s;
        sample_ch.map_start <= start;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        tiles.take_sample(s, start);
    endtask

    // A run of samples; restart puts map_start on the first one, noisy lets a
    // rare stray map_start cut the run short.
    task automatic send_run(input int len, input fill_t fill, input bit restart,
                            input bit noisy);
        sample_t base;
        sample_t s;
        logic    start;
        base = sample_t'($urandom);
        // flat runs often sit right on a threshold or one above it
        if (fill == FILL_FLAT && $urandom_range(0, 1) == 1)
        begin
            base = tiles.levels[$urandom_range(0, NUM_LEVELS - 1)]
                 + sample_t'($urandom_range(0, 1));
        end
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_RANDOM:  s = sample_t'($urandom);
                FILL_FLAT:    s = base;
                FILL_EXTREME: s = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                default:      s = base + sample_t'(i);
            endcase
            start = (i == 0 && restart) || (noisy && $urandom_range(0, 999) == 0);
            offer_sample(s, start);
        end
    endtask

    task automatic wait_tiles();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (tiles.tiles_due.size() != 0) @(posedge clk);
    endtask

    // Quiet point: every tile back, then room for samples that make no tile.
    task automatic drain();
        wait_tiles();
        repeat (SETTLE) @(posedge clk);
    endtask

    // Runs must cover a whole column plus some to reach any window, so most
    // are 140..260 items long; a fifth are 1..140 items long.
    task automatic random_runs(input int budget);
        int    sent;
        int    len;
        fill_t fill;
        sent = 0;
        while (sent < budget)
        begin
            idle_on = stalls_allowed && $urandom_range(0, 3) != 0;
            fill    = fill_t'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, 140);
            else
                len = $urandom_range(140, 260);
            // now and then carry on from the current position instead
            send_run(len, fill, $urandom_range(0, 9) != 0, 1'b1);
            sent += len;
            if ($urandom_range(0, 7) == 0)
            begin
                wait_tiles();
            end
        end
    endtask

    // -------------------------------------------------------------- tile side
    // Takes tiles and stalls in random bursts; on request it holds off for a
    // long stretch so the pipe backs up into the sample channel.
    initial
    begin : tile_sink
        tile_t       got;
        int          hold;
        int unsigned holds_done;
        hold       = 0;
        holds_done = 0;
        tile_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (tile_ch.valid === 1'b1 && tile_ch.ready === 1'b1)
            begin
                got.col  = tile_ch.tile_col;
                got.row  = tile_ch.tile_row;
                got.mean = tile_ch.mean_height;
                got.acol = tile_ch.atlas_col;
                got.arow = tile_ch.atlas_row;
                got.done = tile_ch.map_done;
                tiles.check_tile(got);
            end
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold       = LONG_HOLD;
            end
            else if (hold == 0 && idle_on && $urandom_range(0, 11) == 0)
            begin
                hold = $urandom_range(1, 7);
            end
            if (hold > 0)
            begin
                tile_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                tile_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus
    initial
    begin : stimulus
        sample_t probe [8];
        tiles = new();
        probe = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F};

        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        sample_ch.valid     <= 1'b0;
        sample_ch.sample    <= '0;
        sample_ch.map_start <= 1'b0;
        idle_on        = 1'b0;
        stalls_allowed = 1'b1;
        hold_requests  = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // thresholds must come out of reset at their defaults
        check_levels();

        // Directed: extreme and alternating bit patterns, a map_start on the
        // very first item, one mid-column restart and two restarts in a row.
        idle_on = 1'b1;
        for (int i = 0; i < 20; i++)
        begin
            offer_sample(probe[i % 8], i == 0 || i == 9 || i == 18 || i == 19);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                set_levels(phase);
                check_levels();
            end
            // the last setting runs with no idling on either side
            stalls_allowed = (phase != NUM_PHASES - 1);
            idle_on        = stalls_allowed;
            if (phase == 3)
            begin
                // Two whole columns and more while the tile side holds off,
                // so the pipe fills and the sample channel stalls.
                hold_requests++;
                send_run(LONG_RUN, FILL_RANDOM, 1'b1, 1'b0);
            end
            random_runs(RUN_BUDGET);
        end

        drain();
        if (tiles.mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
